>>> hdl/blst_pkg.sv
`timescale 1ns / 1ps
// shared types and request codes for the bounded list engine
// no dependencies; used by blst_ctrl, blst_dp and the top level

package blst_pkg;

    localparam int REQ_W       = 4;
    localparam int DATA_PORT_W = 32;
    localparam int IDX_W       = 5;

    // request codes
    localparam logic [REQ_W-1:0] REQ_INS_FRONT = 4'd0;
    localparam logic [REQ_W-1:0] REQ_INS_BACK  = 4'd1;
    localparam logic [REQ_W-1:0] REQ_INS_AT    = 4'd2;
    localparam logic [REQ_W-1:0] REQ_REM_FRONT = 4'd3;
    localparam logic [REQ_W-1:0] REQ_REM_BACK  = 4'd4;
    localparam logic [REQ_W-1:0] REQ_REM_AT    = 4'd5;
    localparam logic [REQ_W-1:0] REQ_SEARCH    = 4'd6;
    localparam logic [REQ_W-1:0] REQ_SELECT    = 4'd7;
    localparam logic [REQ_W-1:0] REQ_REPLACE   = 4'd8;

    // where the walk pointer starts
    typedef enum logic [1:0] {
        PTR_ZERO,
        PTR_LAST,
        PTR_NEXT,
        PTR_SEL
    } ptr_src_t;

    // what goes out on position
    typedef enum logic [1:0] {
        POS_NONE,
        POS_MATCH,
        POS_COUNT
    } pos_sel_t;

    typedef struct packed {
        logic     load;
        logic     ptr_init;
        ptr_src_t ptr_src;
        logic     rd;
        logic     walk_fwd;
        logic     wr_shift;
        logic     wr_put;
        logic     cnt_inc;
        logic     cnt_dec;
        logic     finish;
        logic     ok;
        pos_sel_t pos_sel;
        logic     cap_read;
    } blst_cmd_t;

    typedef struct packed {
        logic [REQ_W-1:0] req;
        logic             full;
        logic             empty;
        logic             pos_le_count;
        logic             pos_lt_count;
        logic             pos_is_last;
        logic             ptr_at_pos;
        logic             ptr_is_last;
        logic             match;
    } blst_stat_t;

endpackage

>>> hdl/blst_dp.sv
`timescale 1ns / 1ps
// datapath of the bounded list engine: entry memory, walk pointer, count and result registers
// depends on blst_pkg; driven by blst_ctrl through blst_cmd_t

module blst_dp #(
    parameter int CAPACITY_DEPTH = 16,
    parameter int DATA_WIDTH     = 32
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  blst_pkg::blst_cmd_t               cmd,
    output blst_pkg::blst_stat_t              stat,
    input  logic [blst_pkg::REQ_W-1:0]        req_type,
    input  logic [blst_pkg::DATA_PORT_W-1:0]  value,
    input  logic [blst_pkg::IDX_W-1:0]        index,
    output logic                              ok,
    output logic [blst_pkg::DATA_PORT_W-1:0]  read_data,
    output logic [blst_pkg::IDX_W-1:0]        position,
    output logic [blst_pkg::IDX_W-1:0]        count,
    output logic                              is_full,
    output logic                              is_empty
);

    localparam int AW   = (CAPACITY_DEPTH > 1) ? $clog2(CAPACITY_DEPTH) : 1;
    localparam int CW   = $clog2(CAPACITY_DEPTH + 1);
    localparam int CMPW = (CW > blst_pkg::IDX_W) ? CW : blst_pkg::IDX_W;

    logic [DATA_WIDTH-1:0]       mem [CAPACITY_DEPTH];

    logic [blst_pkg::REQ_W-1:0]  req_reg;
    logic [DATA_WIDTH-1:0]       val_reg;
    logic [blst_pkg::IDX_W-1:0]  idx_reg;
    logic [CW-1:0]               count_reg;
    logic [CW-1:0]               ptr_reg;
    logic [DATA_WIDTH-1:0]       rdata_reg;
    logic [AW-1:0]               rd_addr_reg;
    logic                        rd_valid_reg;
    logic                        ok_reg;
    logic [DATA_WIDTH-1:0]       rd_res_reg;
    logic [CW-1:0]               pos_res_reg;

    logic [63:0]                 value_wide;
    logic [DATA_WIDTH-1:0]       value_in;
    logic [CMPW-1:0]             count_ext;
    logic [CMPW-1:0]             idx_ext;
    logic [CMPW-1:0]             ptr_ext;
    logic [CMPW-1:0]             op_pos;
    logic [CW-1:0]               count_less;
    logic [CW-1:0]               ptr_init_val;
    logic [CW-1:0]               pos_res_next;
    logic                        we;
    logic [AW-1:0]               waddr;
    logic [DATA_WIDTH-1:0]       wdata;
    logic                        full;
    logic                        empty;
    logic [63:0]                 rd_wide;
    logic [CMPW-1:0]             pos_wide;
    logic [CMPW-1:0]             count_wide;

    // fit the 32-bit port to the stored word width
    assign value_wide = 64'(value);
    assign value_in   = value_wide[DATA_WIDTH-1:0];

    assign count_ext  = CMPW'(count_reg);
    assign idx_ext    = CMPW'(idx_reg);
    assign ptr_ext    = CMPW'(ptr_reg);
    assign count_less = count_reg - CW'(1);

    // position the request works on
    always_comb
    begin
        unique case (req_reg)
            blst_pkg::REQ_INS_FRONT,
            blst_pkg::REQ_REM_FRONT: op_pos = '0;
            blst_pkg::REQ_INS_BACK:  op_pos = count_ext;
            blst_pkg::REQ_REM_BACK:  op_pos = count_ext - CMPW'(1);
            default:                 op_pos = idx_ext;
        endcase
    end

    assign full  = (count_reg == CW'(CAPACITY_DEPTH));
    assign empty = (count_reg == '0);

    always_comb
    begin
        stat.req          = req_reg;
        stat.full         = full;
        stat.empty        = empty;
        stat.pos_le_count = (op_pos <= count_ext);
        stat.pos_lt_count = (op_pos < count_ext);
        stat.pos_is_last  = ({1'b0, op_pos} + (CMPW+1)'(1)) == (CMPW+1)'(count_reg);
        stat.ptr_at_pos   = (ptr_ext == op_pos);
        stat.ptr_is_last  = ({1'b0, ptr_ext} + (CMPW+1)'(1)) == (CMPW+1)'(count_reg);
        stat.match        = rd_valid_reg && (rdata_reg == val_reg);
    end

    always_comb
    begin
        unique case (cmd.ptr_src)
            blst_pkg::PTR_ZERO: ptr_init_val = '0;
            blst_pkg::PTR_LAST: ptr_init_val = count_less;
            blst_pkg::PTR_NEXT: ptr_init_val = op_pos[CW-1:0] + CW'(1);
            blst_pkg::PTR_SEL:  ptr_init_val = stat.pos_lt_count ? op_pos[CW-1:0] : count_less;
            default:            ptr_init_val = '0;
        endcase
    end

    // shift writes land one slot away from the entry just read
    always_comb
    begin
        we    = cmd.wr_put || (cmd.wr_shift && rd_valid_reg);
        wdata = cmd.wr_put ? val_reg : rdata_reg;
        if (cmd.wr_put)
        begin
            waddr = op_pos[AW-1:0];
        end
        else if (cmd.walk_fwd)
        begin
            waddr = rd_addr_reg - AW'(1);
        end
        else
        begin
            waddr = rd_addr_reg + AW'(1);
        end
    end

    always_comb
    begin
        unique case (cmd.pos_sel)
            blst_pkg::POS_NONE:  pos_res_next = '0;
            blst_pkg::POS_MATCH: pos_res_next = CW'(rd_addr_reg);
            blst_pkg::POS_COUNT: pos_res_next = count_reg;
            default:             pos_res_next = '0;
        endcase
    end

    // entry memory, registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (cmd.rd)
        begin
            rdata_reg <= mem[ptr_reg[AW-1:0]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            req_reg <= req_type;
            val_reg <= value_in;
            idx_reg <= index;
        end
        if (cmd.ptr_init)
        begin
            ptr_reg <= ptr_init_val;
        end
        else if (cmd.rd)
        begin
            ptr_reg <= cmd.walk_fwd ? (ptr_reg + CW'(1)) : (ptr_reg - CW'(1));
        end
        if (cmd.rd)
        begin
            rd_addr_reg <= ptr_reg[AW-1:0];
        end
        if (cmd.finish)
        begin
            ok_reg      <= cmd.ok;
            rd_res_reg  <= cmd.cap_read ? rdata_reg : '0;
            pos_res_reg <= pos_res_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            rd_valid_reg <= cmd.rd;
            if (cmd.cnt_inc)
            begin
                count_reg <= count_reg + CW'(1);
            end
            else if (cmd.cnt_dec)
            begin
                count_reg <= count_less;
            end
        end
    end

    assign rd_wide    = 64'(rd_res_reg);
    assign pos_wide   = CMPW'(pos_res_reg);
    assign count_wide = CMPW'(count_reg);

    assign ok        = ok_reg;
    assign read_data = rd_wide[blst_pkg::DATA_PORT_W-1:0];
    assign position  = pos_wide[blst_pkg::IDX_W-1:0];
    assign count     = count_wide[blst_pkg::IDX_W-1:0];
    assign is_full   = full;
    assign is_empty  = empty;

endmodule

>>> hdl/blst_ctrl.sv
`timescale 1ns / 1ps
// controller of the bounded list engine: request decode and memory walk sequencing
// depends on blst_pkg; drives blst_dp through blst_cmd_t

module blst_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    output logic                 done,
    output blst_pkg::blst_cmd_t  cmd,
    input  blst_pkg::blst_stat_t stat
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_SHIFT_UP,
        S_UP_DRAIN,
        S_UP_PUT,
        S_SHIFT_DOWN,
        S_DOWN_DRAIN,
        S_SEARCH,
        S_SEARCH_TAIL,
        S_SEL_RD,
        S_SEL_CAP
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   busy_reg;
    logic   done_reg;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                unique case (stat.req)
                    blst_pkg::REQ_INS_FRONT,
                    blst_pkg::REQ_INS_BACK,
                    blst_pkg::REQ_INS_AT:
                    begin
                        if (stat.full || !stat.pos_le_count)
                        begin
                            cmd.finish = 1'b1;
                            state_next = S_IDLE;
                        end
                        else if (!stat.pos_lt_count)
                        begin
                            // append, nothing to move
                            cmd.wr_put  = 1'b1;
                            cmd.cnt_inc = 1'b1;
                            cmd.finish  = 1'b1;
                            cmd.ok      = 1'b1;
                            state_next  = S_IDLE;
                        end
                        else
                        begin
                            cmd.ptr_init = 1'b1;
                            cmd.ptr_src  = blst_pkg::PTR_LAST;
                            state_next   = S_SHIFT_UP;
                        end
                    end
                    blst_pkg::REQ_REM_FRONT,
                    blst_pkg::REQ_REM_BACK,
                    blst_pkg::REQ_REM_AT:
                    begin
                        if (stat.empty || !stat.pos_lt_count)
                        begin
                            cmd.finish = 1'b1;
                            state_next = S_IDLE;
                        end
                        else if (stat.pos_is_last)
                        begin
                            cmd.cnt_dec = 1'b1;
                            cmd.finish  = 1'b1;
                            cmd.ok      = 1'b1;
                            state_next  = S_IDLE;
                        end
                        else
                        begin
                            cmd.ptr_init = 1'b1;
                            cmd.ptr_src  = blst_pkg::PTR_NEXT;
                            state_next   = S_SHIFT_DOWN;
                        end
                    end
                    blst_pkg::REQ_SEARCH:
                    begin
                        if (stat.empty)
                        begin
                            cmd.finish  = 1'b1;
                            cmd.pos_sel = blst_pkg::POS_COUNT;
                            state_next  = S_IDLE;
                        end
                        else
                        begin
                            cmd.ptr_init = 1'b1;
                            cmd.ptr_src  = blst_pkg::PTR_ZERO;
                            state_next   = S_SEARCH;
                        end
                    end
                    blst_pkg::REQ_SELECT:
                    begin
                        if (stat.empty)
                        begin
                            cmd.finish = 1'b1;
                            state_next = S_IDLE;
                        end
                        else
                        begin
                            cmd.ptr_init = 1'b1;
                            cmd.ptr_src  = blst_pkg::PTR_SEL;
                            state_next   = S_SEL_RD;
                        end
                    end
                    blst_pkg::REQ_REPLACE:
                    begin
                        cmd.finish = 1'b1;
                        state_next = S_IDLE;
                        if (!stat.empty && stat.pos_lt_count)
                        begin
                            cmd.wr_put = 1'b1;
                            cmd.ok     = 1'b1;
                        end
                    end
                    default:
                    begin
                        cmd.finish = 1'b1;
                        state_next = S_IDLE;
                    end
                endcase
            end
            S_SHIFT_UP:
            begin
                // walk down from the back, each entry moves one slot up
                cmd.rd       = 1'b1;
                cmd.wr_shift = 1'b1;
                if (stat.ptr_at_pos)
                begin
                    state_next = S_UP_DRAIN;
                end
            end
            S_UP_DRAIN:
            begin
                cmd.wr_shift = 1'b1;
                state_next   = S_UP_PUT;
            end
            S_UP_PUT:
            begin
                cmd.wr_put  = 1'b1;
                cmd.cnt_inc = 1'b1;
                cmd.finish  = 1'b1;
                cmd.ok      = 1'b1;
                state_next  = S_IDLE;
            end
            S_SHIFT_DOWN:
            begin
                // walk up from the gap, each entry moves one slot down
                cmd.rd       = 1'b1;
                cmd.walk_fwd = 1'b1;
                cmd.wr_shift = 1'b1;
                if (stat.ptr_is_last)
                begin
                    state_next = S_DOWN_DRAIN;
                end
            end
            S_DOWN_DRAIN:
            begin
                cmd.walk_fwd = 1'b1;
                cmd.wr_shift = 1'b1;
                cmd.cnt_dec  = 1'b1;
                cmd.finish   = 1'b1;
                cmd.ok       = 1'b1;
                state_next   = S_IDLE;
            end
            S_SEARCH:
            begin
                if (stat.match)
                begin
                    cmd.finish  = 1'b1;
                    cmd.ok      = 1'b1;
                    cmd.pos_sel = blst_pkg::POS_MATCH;
                    state_next  = S_IDLE;
                end
                else
                begin
                    cmd.rd       = 1'b1;
                    cmd.walk_fwd = 1'b1;
                    if (stat.ptr_is_last)
                    begin
                        state_next = S_SEARCH_TAIL;
                    end
                end
            end
            S_SEARCH_TAIL:
            begin
                cmd.finish = 1'b1;
                state_next = S_IDLE;
                if (stat.match)
                begin
                    cmd.ok      = 1'b1;
                    cmd.pos_sel = blst_pkg::POS_MATCH;
                end
                else
                begin
                    cmd.pos_sel = blst_pkg::POS_COUNT;
                end
            end
            S_SEL_RD:
            begin
                cmd.rd     = 1'b1;
                state_next = S_SEL_CAP;
            end
            S_SEL_CAP:
            begin
                cmd.finish   = 1'b1;
                cmd.ok       = 1'b1;
                cmd.cap_read = 1'b1;
                state_next   = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= cmd.finish;
            if (cmd.load)
            begin
                busy_reg <= 1'b1;
            end
            else if (cmd.finish)
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    assign busy = busy_reg;
    assign done = done_reg;

endmodule

>>> hdl/bounded_list_engine_top.sv
`timescale 1ns / 1ps
// done follows the dispatch state directly for end inserts/removes, replace and refused
// requests; shifts, searches and selects pass through their walk or read states first
// throughput: one item at a time, the next start is taken in the cycle done is high
// the walk pace is set by the single read port and single write port of the entry memory
// reset: rst_n clears the count, so the list is empty; entry contents are not cleared
// results cannot be stalled: each result is valid for the single cycle done is high

module bounded_list_engine_top #(
    parameter int CAPACITY_DEPTH = 16,
    parameter int DATA_WIDTH     = 32
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // command side
    input  logic                              start,
    output logic                              busy,
    input  logic [blst_pkg::REQ_W-1:0]        req_type,
    input  logic [blst_pkg::DATA_PORT_W-1:0]  value,
    input  logic [blst_pkg::IDX_W-1:0]        index,
    // result side
    output logic                              done,
    output logic                              ok,
    output logic [blst_pkg::DATA_PORT_W-1:0]  read_data,
    output logic [blst_pkg::IDX_W-1:0]        position,
    output logic [blst_pkg::IDX_W-1:0]        count,
    output logic                              is_full,
    output logic                              is_empty
);

    // command and status between the sequencer and the datapath
    blst_pkg::blst_cmd_t  cmd;
    blst_pkg::blst_stat_t stat;

    // controller: decodes the request once loaded, then steps the memory walk
    //   inserts shift entries up from the back, removes shift down from the gap,
    //   search reads from the front and stops at the first match
    blst_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .done  (done),
        .cmd   (cmd),
        .stat  (stat)
    );

    // datapath: entry memory with registered read, walk pointer, entry count
    //   and the result registers that hold steady while done is high
    blst_dp #(
        .CAPACITY_DEPTH (CAPACITY_DEPTH),
        .DATA_WIDTH     (DATA_WIDTH)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .req_type  (req_type),
        .value     (value),
        .index     (index),
        .ok        (ok),
        .read_data (read_data),
        .position  (position),
        .count     (count),
        .is_full   (is_full),
        .is_empty  (is_empty)
    );

endmodule

>>> tb/sv/list_result_checker.sv
`timescale 1ns / 1ps
// result checker for the bounded list engine: keeps a shadow copy of the list,
// predicts one reply per accepted item and compares it with the done strobe
// depends on blst_pkg for the request codes and port widths

module list_result_checker #(
    parameter int CAPACITY_DEPTH = 16,
    parameter int DATA_WIDTH     = 32
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    input  logic                             busy,
    input  logic [blst_pkg::REQ_W-1:0]       req_type,
    input  logic [blst_pkg::DATA_PORT_W-1:0] value,
    input  logic [blst_pkg::IDX_W-1:0]       index,
    input  logic                             done,
    input  logic                             ok,
    input  logic [blst_pkg::DATA_PORT_W-1:0] read_data,
    input  logic [blst_pkg::IDX_W-1:0]       position,
    input  logic [blst_pkg::IDX_W-1:0]       count,
    input  logic                             is_full,
    input  logic                             is_empty,
    output int                               fail_count,
    output int                               outstanding
);

    localparam logic [blst_pkg::DATA_PORT_W-1:0] DATA_MASK =
        (DATA_WIDTH >= blst_pkg::DATA_PORT_W) ? '1 :
        (blst_pkg::DATA_PORT_W'(1) << DATA_WIDTH) - blst_pkg::DATA_PORT_W'(1);

    typedef struct packed {
        logic                             ok;
        logic [blst_pkg::DATA_PORT_W-1:0] read_data;
        logic [blst_pkg::IDX_W-1:0]       position;
        logic [blst_pkg::IDX_W-1:0]       count;
        logic                             full;
        logic                             empty;
    } list_reply_t;

    logic [blst_pkg::DATA_PORT_W-1:0] shadow_entries [CAPACITY_DEPTH];
    int                               shadow_len;
    list_reply_t                      expected_replies [$];
    int                               accepted_n;
    int                               checked_n;

    assign outstanding = accepted_n - checked_n;

    // insert with the entries at and after the slot moved one place back
    function automatic logic list_put(int at, logic [blst_pkg::DATA_PORT_W-1:0] v);
        int k;
        if (shadow_len >= CAPACITY_DEPTH || at > shadow_len)
            return 1'b0;
        for (k = shadow_len; k > at; k--)
            shadow_entries[k] = shadow_entries[k-1];
        shadow_entries[at] = v;
        shadow_len++;
        return 1'b1;
    endfunction

    // remove with the entries after the slot moved one place forward
    function automatic logic list_take(int at);
        int k;
        if (shadow_len == 0 || at >= shadow_len)
            return 1'b0;
        for (k = at; k + 1 < shadow_len; k++)
            shadow_entries[k] = shadow_entries[k+1];
        shadow_len--;
        return 1'b1;
    endfunction

    function automatic list_reply_t apply_request(logic [blst_pkg::REQ_W-1:0] req,
                                                  logic [blst_pkg::DATA_PORT_W-1:0] v_in,
                                                  logic [blst_pkg::IDX_W-1:0] ix);
        list_reply_t                      r;
        logic [blst_pkg::DATA_PORT_W-1:0] v;
        int                               k;
        int                               at;
        r = '0;
        v = v_in & DATA_MASK;
        case (req)
            blst_pkg::REQ_INS_FRONT: r.ok = list_put(0, v);
            blst_pkg::REQ_INS_BACK:  r.ok = list_put(shadow_len, v);
            blst_pkg::REQ_INS_AT:    r.ok = list_put(int'(ix), v);
            blst_pkg::REQ_REM_FRONT: r.ok = list_take(0);
            blst_pkg::REQ_REM_BACK:
            begin
                if (shadow_len != 0)
                    r.ok = list_take(shadow_len - 1);
            end
            blst_pkg::REQ_REM_AT:    r.ok = list_take(int'(ix));
            blst_pkg::REQ_SEARCH:
            begin
                r.position = blst_pkg::IDX_W'(shadow_len);
                for (k = 0; k < shadow_len; k++)
                begin
                    if (!r.ok && shadow_entries[k] == v)
                    begin
                        r.position = blst_pkg::IDX_W'(k);
                        r.ok       = 1'b1;
                    end
                end
            end
            blst_pkg::REQ_SELECT:
            begin
                // past the end reads the last entry
                if (shadow_len != 0)
                begin
                    at          = (int'(ix) < shadow_len) ? int'(ix) : shadow_len - 1;
                    r.read_data = shadow_entries[at];
                    r.ok        = 1'b1;
                end
            end
            blst_pkg::REQ_REPLACE:
            begin
                if (int'(ix) < shadow_len)
                begin
                    shadow_entries[ix] = v;
                    r.ok               = 1'b1;
                end
            end
            default: ;
        endcase
        r.count = blst_pkg::IDX_W'(shadow_len);
        r.full  = (shadow_len == CAPACITY_DEPTH);
        r.empty = (shadow_len == 0);
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        list_reply_t got;
        list_reply_t want;
        if (!rst_n)
        begin
            expected_replies.delete();
            shadow_len = 0;
            accepted_n <= 0;
            checked_n  <= 0;
            fail_count <= 0;
        end
        else
        begin
            if (done)
            begin
                got = {ok, read_data, position, count, is_full, is_empty};
                if (expected_replies.size() == 0)
                begin
                    if (fail_count < 10)
                        $display("tb: result %0d arrived with no item outstanding", checked_n);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    want = expected_replies.pop_front();
                    if (got !== want)
                    begin
                        if (fail_count < 10)
                        begin
                            $write("tb: mismatch on result %0d (expected/actual): ok %0b/%0b",
                                   checked_n, want.ok, got.ok);
                            $display(" read_data %h/%h position %0d/%0d count %0d/%0d",
                                     want.read_data, got.read_data, want.position,
                                     got.position, want.count, got.count,
                                     " full %0b/%0b empty %0b/%0b",
                                     want.full, got.full, want.empty, got.empty);
                        end
                        fail_count <= fail_count + 1;
                    end
                end
                checked_n <= checked_n + 1;
            end
            if (start && !busy)
            begin
                expected_replies.push_back(apply_request(req_type, value, index));
                accepted_n <= accepted_n + 1;
            end
        end
    end

endmodule

>>> tb/sv/tb_bounded_list_engine_top.sv
`timescale 1ns / 1ps
// testbench top for the bounded list engine: clock, reset, request stimulus and verdict
// depends on blst_pkg, bounded_list_engine_top and list_result_checker

module tb_bounded_list_engine_top;

    localparam int CAPACITY_DEPTH = 16;
    localparam int DATA_WIDTH     = 32;

    logic                             clk       = 1'b0;
    logic                             rst_n     = 1'b0;
    logic                             start     = 1'b0;
    logic [blst_pkg::REQ_W-1:0]       req_type  = blst_pkg::REQ_INS_FRONT;
    logic [blst_pkg::DATA_PORT_W-1:0] value     = '0;
    logic [blst_pkg::IDX_W-1:0]       index     = '0;
    logic                             busy;
    logic                             done;
    logic                             ok;
    logic [blst_pkg::DATA_PORT_W-1:0] read_data;
    logic [blst_pkg::IDX_W-1:0]       position;
    logic [blst_pkg::IDX_W-1:0]       count;
    logic                             is_full;
    logic                             is_empty;
    int                               fail_count;
    int                               outstanding;

    // 20 ns period
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    bounded_list_engine_top #(
        .CAPACITY_DEPTH (CAPACITY_DEPTH),
        .DATA_WIDTH     (DATA_WIDTH)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .req_type  (req_type),
        .value     (value),
        .index     (index),
        .done      (done),
        .ok        (ok),
        .read_data (read_data),
        .position  (position),
        .count     (count),
        .is_full   (is_full),
        .is_empty  (is_empty)
    );

    // shadow list, prediction and comparison all live in the checker
    list_result_checker #(
        .CAPACITY_DEPTH (CAPACITY_DEPTH),
        .DATA_WIDTH     (DATA_WIDTH)
    ) checker_u (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .req_type    (req_type),
        .value       (value),
        .index       (index),
        .done        (done),
        .ok          (ok),
        .read_data   (read_data),
        .position    (position),
        .count       (count),
        .is_full     (is_full),
        .is_empty    (is_empty),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    // present one item and hold it until the edge that takes it
    // start stays high on return so a back-to-back item needs no extra toggle
    task automatic issue(input logic [blst_pkg::REQ_W-1:0] r,
                         input logic [blst_pkg::DATA_PORT_W-1:0] v,
                         input logic [blst_pkg::IDX_W-1:0] ix);
        start    <= 1'b1;
        req_type <= r;
        value    <= v;
        index    <= ix;
        do
            @(posedge clk);
        while (busy);
    endtask

    // hard stop in case the block hangs
    initial
    begin
        #10ms;
        $display("tb: failure");
        $finish;
    end

    initial
    begin
        logic [blst_pkg::DATA_PORT_W-1:0] pool [6];
        int                               idle_pct [4];
        int                               phase;
        int                               n;
        int                               roll;
        int                               ins_share;
        int                               rem_share;
        int                               mode_left;
        int                               spin;
        bit                               filling;
        logic [blst_pkg::REQ_W-1:0]       r;
        logic [blst_pkg::DATA_PORT_W-1:0] v;
        logic [blst_pkg::IDX_W-1:0]       ix;

        // sender idle share per phase; the receiver side cannot stall
        idle_pct = '{0, 78, 31, 0};

        // values reused often so that searches hit and duplicates occur
        pool[0] = '0;
        pool[1] = '1;
        for (n = 2; n < 6; n++)
            pool[n] = $urandom;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // ---- directed part ----
        // everything refused on an empty list
        issue(blst_pkg::REQ_SELECT, 32'h0000_0000, 5'd0);
        issue(blst_pkg::REQ_SEARCH, 32'h0000_0000, 5'd0);
        issue(blst_pkg::REQ_REM_FRONT, 32'h0000_0000, 5'd0);
        issue(blst_pkg::REQ_REM_BACK, 32'h0000_0000, 5'd0);
        issue(blst_pkg::REQ_REM_AT, 32'h0000_0000, 5'd0);
        issue(blst_pkg::REQ_REPLACE, 32'hFFFF_FFFF, 5'd0);
        // unused request codes, lowest and highest
        issue(blst_pkg::REQ_REPLACE + 4'd1, 32'h0000_0000, 5'd0);
        issue(blst_pkg::REQ_REPLACE + 4'd7, 32'hFFFF_FFFF, 5'd16);
        // insert above count is refused, at count appends
        issue(blst_pkg::REQ_INS_AT, 32'h1111_1111, 5'd1);
        issue(blst_pkg::REQ_INS_AT, 32'hA5A5_A5A5, 5'd0);
        issue(blst_pkg::REQ_INS_FRONT, 32'hFFFF_FFFF, 5'd0);
        issue(blst_pkg::REQ_INS_BACK, 32'h0000_0000, 5'd0);
        issue(blst_pkg::REQ_INS_AT, 32'h1234_5678, 5'd3);
        // middle insert shifts the tail
        issue(blst_pkg::REQ_INS_AT, 32'h5555_AAAA, 5'd1);
        // search hit and miss
        issue(blst_pkg::REQ_SEARCH, 32'h0000_0000, 5'd0);
        issue(blst_pkg::REQ_SEARCH, 32'hDEAD_BEEF, 5'd0);
        // select past the end returns the last entry
        issue(blst_pkg::REQ_SELECT, 32'h0000_0000, 5'd16);
        issue(blst_pkg::REQ_SELECT, 32'h0000_0000, 5'd2);
        issue(blst_pkg::REQ_REPLACE, 32'h0000_0001, 5'd0);
        issue(blst_pkg::REQ_REPLACE, 32'h7777_7777, 5'd16);
        issue(blst_pkg::REQ_REM_AT, 32'h0000_0000, 5'd16);
        issue(blst_pkg::REQ_REM_AT, 32'h0000_0000, 5'd1);
        issue(blst_pkg::REQ_REM_BACK, 32'h0000_0000, 5'd0);
        issue(blst_pkg::REQ_REM_FRONT, 32'h0000_0000, 5'd0);

        // ---- random part ----
        for (phase = 0; phase < 4; phase++)
        begin
            // drive the list to full, then push against it
            if (phase == 0)
            begin
                for (n = 0; n < 18; n++)
                    issue(($urandom_range(1) != 0) ? blst_pkg::REQ_INS_FRONT
                                                   : blst_pkg::REQ_INS_BACK,
                          $urandom, 5'(n));
                issue(blst_pkg::REQ_INS_AT, $urandom, 5'd0);
                issue(blst_pkg::REQ_INS_AT, $urandom, 5'd16);
            end

            filling   = ($urandom_range(1) != 0);
            mode_left = $urandom_range(60, 25);
            for (n = 0; n < 310; n++)
            begin
                // alternate between growing and shrinking so count sweeps both ends
                if (mode_left == 0)
                begin
                    filling   = !filling;
                    mode_left = $urandom_range(60, 25);
                end
                mode_left--;
                ins_share = filling ? 52 : 22;
                rem_share = filling ? 20 : 50;

                roll = $urandom_range(99);
                if (roll < 2)
                    r = blst_pkg::REQ_REPLACE + 4'($urandom_range(7, 1));
                else if (roll < 2 + ins_share)
                begin
                    case ($urandom_range(2))
                        0:       r = blst_pkg::REQ_INS_FRONT;
                        1:       r = blst_pkg::REQ_INS_BACK;
                        default: r = blst_pkg::REQ_INS_AT;
                    endcase
                end
                else if (roll < 2 + ins_share + rem_share)
                begin
                    case ($urandom_range(2))
                        0:       r = blst_pkg::REQ_REM_FRONT;
                        1:       r = blst_pkg::REQ_REM_BACK;
                        default: r = blst_pkg::REQ_REM_AT;
                    endcase
                end
                else
                begin
                    case ($urandom_range(2))
                        0:       r = blst_pkg::REQ_SEARCH;
                        1:       r = blst_pkg::REQ_SELECT;
                        default: r = blst_pkg::REQ_REPLACE;
                    endcase
                end

                v  = ($urandom_range(99) < 60) ? pool[$urandom_range(5)] : $urandom;
                // small indexes often, so indexed requests land inside short lists
                ix = ($urandom_range(1) != 0) ? 5'($urandom_range(4)) : 5'($urandom_range(16));

                // random sender gaps ahead of the item
                while ($urandom_range(99) < idle_pct[phase])
                begin
                    start <= 1'b0;
                    @(posedge clk);
                end
                issue(r, v, ix);
            end

            // hold off until every reply of this phase is back
            start <= 1'b0;
            @(posedge clk);
            while (outstanding != 0)
                @(posedge clk);
        end

        // drain: wait for the last replies, then cover the longest walk
        start <= 1'b0;
        for (spin = 0; spin < 2000 && outstanding != 0; spin++)
            @(posedge clk);
        repeat (CAPACITY_DEPTH + 8) @(posedge clk);

        if (fail_count == 0 && outstanding == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
